// ===== src/sbwf_pkg.sv =====
// shared types and constants of the sync bit word framer
package sbwf_pkg;

	localparam int VALUE_W = 14;
	localparam int HALF_W  = 7;
	localparam int BYTE_W  = 8;
	localparam int SUM_W   = 16;

	localparam logic [BYTE_W-1:0] SYNC_MARK = 8'h80;

	// one classified request: both data bytes plus the frame checksum
	typedef struct packed {
		logic [BYTE_W-1:0]  hi;
		logic [HALF_W-1:0]  lo;
		logic               closing;
		logic [VALUE_W-1:0] csum;
	} cmd_t;

	// a queue slot or push request with its valid flag
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} slot_t;

endpackage

// ===== src/sbwf_if.sv =====
// handshake channels of the sync bit word framer

interface sbwf_item_if;
	logic                            valid;
	logic                            ready;
	logic [sbwf_pkg::VALUE_W-1:0]    value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

interface sbwf_byte_if;
	logic                            valid;
	logic                            ready;
	logic [sbwf_pkg::BYTE_W-1:0]     out_byte;
	logic                            last_of_item;
	logic                            end_of_frame;

	modport source(output valid, output out_byte, output last_of_item,
		output end_of_frame, input ready);
	modport sink(input valid, input out_byte, input last_of_item,
		input end_of_frame, output ready);
endinterface

// ===== src/sync_bit_word_framer.sv =====
// top level of the sync bit word framer
//
// Input channel item carries one 14-bit value per request. Output channel
// result carries one 8-bit byte per request with last_of_item and
// end_of_frame flags. Every value gives its high 7 bits and then its low
// 7 bits; the first byte of a frame has bit 7 set. After the WORDS-th
// value of a frame, the low 14 bits of the 16-bit byte sum follow as two
// more 7-bit bytes, the second one flagged end_of_frame.
// A value's first byte passes a queue entry and then the output register.
// The output gives one byte per cycle while the receiver holds ready high,
// so a value gives two bytes, four on the closing value of a frame; the byte serializer sets this rate.
// A two-entry queue sits between the input side and the serializer, so a
// new value is taken while earlier bytes still wait or go out.
// Reset clears the word count, the sum, the queue and the output valid.
// When the receiver holds ready low, the output byte holds, the queue
// fills and item.ready drops once both entries are taken.
module sync_bit_word_framer #(
	parameter int WORDS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	sbwf_item_if.sink   item,
	sbwf_byte_if.source result
);

	sbwf_pkg::slot_t push;
	sbwf_pkg::slot_t head;
	logic            full;
	logic            pop;

	sbwf_front #(
		.WORDS(WORDS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.full  (full),
		.push  (push)
	);

	sbwf_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.full  (full),
		.head  (head)
	);

	sbwf_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.pop   (pop),
		.result(result)
	);

endmodule

// ===== src/sbwf_front.sv =====
// front end: accepts values, adds the sync mark, keeps word count and running sum
module sbwf_front #(
	parameter int WORDS = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	sbwf_item_if.sink       item,
	input  logic            full,
	output sbwf_pkg::slot_t push
);

	localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic [IDX_W-1:0]            idx_q;
	logic [sbwf_pkg::SUM_W-1:0]  sum_q;
	logic [sbwf_pkg::SUM_W-1:0]  sum_next;
	logic [sbwf_pkg::BYTE_W-1:0] hi;
	logic [sbwf_pkg::HALF_W-1:0] lo;
	logic                        closing;
	logic                        accept;

	assign item.ready = !full;
	assign accept     = item.valid && !full;

	// split the value and mark the first byte of a frame
	always_comb begin
		hi = {1'b0, item.value[sbwf_pkg::VALUE_W-1:sbwf_pkg::HALF_W]};
		if (idx_q == '0) begin
			hi = hi | sbwf_pkg::SYNC_MARK;
		end
		lo       = item.value[sbwf_pkg::HALF_W-1:0];
		closing  = (idx_q == IDX_W'(WORDS - 1));
		sum_next = sum_q + sbwf_pkg::SUM_W'(hi) + sbwf_pkg::SUM_W'(lo);
	end

	// request toward the queue
	always_comb begin
		push.valid       = accept;
		push.cmd.hi      = hi;
		push.cmd.lo      = lo;
		push.cmd.closing = closing;
		push.cmd.csum    = sum_next[sbwf_pkg::VALUE_W-1:0];
	end

	// frame position and checksum, cleared after the closing value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			if (closing) begin
				idx_q <= '0;
				sum_q <= '0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
				sum_q <= sum_next;
			end
		end
	end

endmodule

// ===== src/sbwf_queue.sv =====
// two-entry request queue between front and back
module sbwf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  sbwf_pkg::slot_t push,
	input  logic            pop,
	output logic            full,
	output sbwf_pkg::slot_t head
);

	logic           v0_q;
	logic           v1_q;
	sbwf_pkg::cmd_t s0_q;
	sbwf_pkg::cmd_t s1_q;

	assign full       = v1_q;
	assign head.valid = v0_q;
	assign head.cmd   = s0_q;

	// occupancy flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else if (pop && v0_q) begin
			if (v1_q) begin
				v0_q <= 1'b1;
				v1_q <= 1'b0;
			end else begin
				v0_q <= push.valid;
			end
		end else if (push.valid) begin
			if (!v0_q) begin
				v0_q <= 1'b1;
			end else begin
				v1_q <= 1'b1;
			end
		end
	end

	// entry storage, shifting toward the head
	always_ff @(posedge clk) begin
		if (pop && v0_q) begin
			if (v1_q) begin
				s0_q <= s1_q;
			end else if (push.valid) begin
				s0_q <= push.cmd;
			end
		end else if (push.valid) begin
			if (!v0_q) begin
				s0_q <= push.cmd;
			end else begin
				s1_q <= push.cmd;
			end
		end
	end

endmodule

// ===== src/sbwf_back.sv =====
// back end: serializes each request into two or four bytes, one per cycle while the receiver is ready
module sbwf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  sbwf_pkg::slot_t head,
	output logic            pop,
	sbwf_byte_if.source     result
);

	localparam logic [1:0] PH_HI  = 2'd0;
	localparam logic [1:0] PH_LO  = 2'd1;
	localparam logic [1:0] PH_CHI = 2'd2;
	localparam logic [1:0] PH_CLO = 2'd3;

	logic [1:0]                  phase_q;
	logic                        ovalid_q;
	logic [sbwf_pkg::BYTE_W-1:0] obyte_q;
	logic                        olast_q;
	logic                        oeof_q;
	logic [sbwf_pkg::BYTE_W-1:0] byte_sel;
	logic                        last_sel;
	logic                        eof_sel;
	logic                        done;
	logic                        load;

	assign result.valid        = ovalid_q;
	assign result.out_byte     = obyte_q;
	assign result.last_of_item = olast_q;
	assign result.end_of_frame = oeof_q;

	assign load = head.valid && (!ovalid_q || result.ready);
	assign pop  = load && done;

	// pick the byte for the current phase
	always_comb begin
		byte_sel = '0;
		last_sel = 1'b0;
		eof_sel  = 1'b0;
		done     = 1'b0;
		case (phase_q)
			PH_HI: begin
				byte_sel = head.cmd.hi;
			end
			PH_LO: begin
				byte_sel = {1'b0, head.cmd.lo};
				last_sel = !head.cmd.closing;
				done     = !head.cmd.closing;
			end
			PH_CHI: begin
				byte_sel = {1'b0, head.cmd.csum[sbwf_pkg::VALUE_W-1:sbwf_pkg::HALF_W]};
			end
			PH_CLO: begin
				byte_sel = {1'b0, head.cmd.csum[sbwf_pkg::HALF_W-1:0]};
				last_sel = 1'b1;
				eof_sel  = 1'b1;
				done     = 1'b1;
			end
			default: begin
				byte_sel = '0;
			end
		endcase
	end

	// phase sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HI;
			ovalid_q <= 1'b0;
		end else begin
			if (!ovalid_q || result.ready) begin
				ovalid_q <= head.valid;
			end
			if (load) begin
				phase_q <= done ? PH_HI : phase_q + 2'd1;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			obyte_q <= byte_sel;
			olast_q <= last_sel;
			oeof_q  <= eof_sel;
		end
	end

endmodule

// ===== src/sbwf_checker.sv =====
// port-level checks of the sync bit word framer, bound to the top level
module sbwf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [sbwf_pkg::BYTE_W-1:0] out_byte,
	input logic                        last_of_item,
	input logic                        end_of_frame
);

	// the frame-closing byte is always the last byte of its value
	a_eof_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> last_of_item)
		else $error("end_of_frame without last_of_item");

	// a sync-marked byte opens a value and never closes one
	a_sync_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_byte[7] |-> !last_of_item && !end_of_frame)
		else $error("sync byte flagged as last");

	// a stalled byte stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped under stall");

	// a stalled byte keeps its payload
	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable(out_byte) && $stable(last_of_item) && $stable(end_of_frame))
		else $error("output payload changed under stall");

endmodule

bind sync_bit_word_framer sbwf_checker u_sbwf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_byte    (result.out_byte),
	.last_of_item(result.last_of_item),
	.end_of_frame(result.end_of_frame)
);
